// ===== rtl/hfp_pkg.sv =====
// Shared constants, types and helpers for the HMM forward probability unit.
package hfp_pkg;

    localparam int NumStates  = 8;
    localparam int NumSymbols = 16;
    localparam int ProbW      = 32;
    localparam int RowW       = 3;
    localparam int ColW       = 4;
    localparam int SymbolW    = 4;
    localparam int StateW     = $clog2(NumStates);
    localparam int SymIdxW    = $clog2(NumSymbols);
    localparam int AccW       = ProbW + StateW;
    localparam int CntW       = $clog2(NumStates + 1);

    localparam logic [ProbW-1:0] ProbMax = '1;

    typedef enum logic [1:0] {
        ACT_TRANS   = 2'd0,
        ACT_EMIS    = 2'd1,
        ACT_INIT    = 2'd2,
        ACT_OBSERVE = 2'd3
    } action_t;

    typedef struct packed {
        logic              en;
        action_t           action;
        logic [RowW-1:0]   row;
        logic [ColW-1:0]   col;
        logic [ProbW-1:0]  weight;
    } tbl_wr_t;

    typedef struct packed {
        logic               load_rot;
        logic               shift;
        logic               mac_mul;
        logic               mac_acc;
        logic               emis_mul;
        logic               alpha_wr;
        logic               use_init;
        logic               sym_ok;
        logic [SymIdxW-1:0] sym;
    } cell_cmd_t;

    function automatic logic [ProbW-1:0] sat_prob(input logic [AccW-1:0] v);
        logic [ProbW-1:0] r;
        r = (|v[AccW-1:ProbW]) ? ProbMax : v[ProbW-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/hfp_cell.sv =====
// One state cell: table slices, forward value, ring stage and multiply-accumulate.
module hfp_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hfp_pkg::StateW-1:0]    idx,
    input  hfp_pkg::cell_cmd_t            cmd,
    input  hfp_pkg::tbl_wr_t              wr,
    input  logic [hfp_pkg::ProbW-1:0]     rot_in,
    output logic [hfp_pkg::ProbW-1:0]     rot_out
);

    logic [hfp_pkg::ProbW-1:0]    trans_reg [hfp_pkg::NumStates];
    logic [hfp_pkg::ProbW-1:0]    emis_reg  [hfp_pkg::NumSymbols];
    logic [hfp_pkg::ProbW-1:0]    init_reg;
    logic [hfp_pkg::ProbW-1:0]    alpha_reg;
    logic [hfp_pkg::ProbW-1:0]    rot_reg;
    logic [hfp_pkg::StateW-1:0]   src_reg;
    logic [hfp_pkg::StateW-1:0]   src_next;
    logic [hfp_pkg::AccW-1:0]     acc_reg;
    logic [2*hfp_pkg::ProbW-1:0]  prod_reg;
    logic [2*hfp_pkg::ProbW-1:0]  prod_next;
    logic [hfp_pkg::ProbW-1:0]    mul_a;
    logic [hfp_pkg::ProbW-1:0]    mul_b;
    logic                         trans_we;
    logic                         emis_we;
    logic                         init_we;

    assign rot_out = rot_reg;

    assign trans_we = wr.en && (wr.action == hfp_pkg::ACT_TRANS)
                      && (int'(wr.row) < hfp_pkg::NumStates)
                      && (wr.col == hfp_pkg::ColW'(idx));
    assign emis_we  = wr.en && (wr.action == hfp_pkg::ACT_EMIS)
                      && (wr.row == hfp_pkg::RowW'(idx))
                      && (int'(wr.col) < hfp_pkg::NumSymbols);
    assign init_we  = wr.en && (wr.action == hfp_pkg::ACT_INIT)
                      && (wr.row == hfp_pkg::RowW'(idx));

    assign src_next = (src_reg == hfp_pkg::StateW'(hfp_pkg::NumStates - 1))
                      ? '0 : src_reg + 1'b1;

    always_comb
    begin
        if (cmd.emis_mul)
        begin
            mul_a = cmd.use_init ? init_reg : hfp_pkg::sat_prob(acc_reg);
            mul_b = cmd.sym_ok ? emis_reg[cmd.sym] : '0;
        end
        else
        begin
            mul_a = rot_reg;
            mul_b = trans_reg[src_reg];
        end
    end

    assign prod_next = (2*hfp_pkg::ProbW)'(mul_a) * (2*hfp_pkg::ProbW)'(mul_b);

    always_ff @(posedge clk)
    begin
        if (trans_we)
        begin
            trans_reg[wr.row[hfp_pkg::StateW-1:0]] <= wr.weight;
        end
        if (emis_we)
        begin
            emis_reg[wr.col[hfp_pkg::SymIdxW-1:0]] <= wr.weight;
        end
        if (init_we)
        begin
            init_reg <= wr.weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
        end
        else if (cmd.alpha_wr)
        begin
            alpha_reg <= prod_reg[2*hfp_pkg::ProbW-1:hfp_pkg::ProbW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rot)
        begin
            rot_reg <= alpha_reg;
            src_reg <= idx;
            acc_reg <= '0;
        end
        else if (cmd.alpha_wr)
        begin
            rot_reg <= prod_reg[2*hfp_pkg::ProbW-1:hfp_pkg::ProbW];
            src_reg <= idx;
        end
        else
        begin
            if (cmd.shift)
            begin
                rot_reg <= rot_in;
                src_reg <= src_next;
            end
            if (cmd.mac_acc)
            begin
                acc_reg <= acc_reg
                           + hfp_pkg::AccW'(prod_reg[2*hfp_pkg::ProbW-1:hfp_pkg::ProbW]);
            end
        end
        if (cmd.mac_mul || cmd.emis_mul)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== rtl/hfp_ctrl.sv =====
// Sequencer: input decode, phase control of the cell ring, final sum and result word.
module hfp_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [hfp_pkg::RowW-1:0]     row_state,
    input  logic [hfp_pkg::ColW-1:0]     column_index,
    input  logic [hfp_pkg::ProbW-1:0]    weight,
    input  logic [hfp_pkg::SymbolW-1:0]  symbol,
    input  logic                         first_item,
    input  logic                         last_item,
    input  logic [hfp_pkg::ProbW-1:0]    rot0,
    output hfp_pkg::tbl_wr_t             wr,
    output hfp_pkg::cell_cmd_t           cmd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hfp_pkg::ProbW-1:0]    sequence_probability
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_EMUL = 6'b000100,
        S_EWR  = 6'b001000,
        S_SUM  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [hfp_pkg::CntW-1:0]      cnt_reg;
    logic [hfp_pkg::CntW-1:0]      cnt_next;
    logic [hfp_pkg::AccW-1:0]      sum_reg;
    logic [hfp_pkg::AccW-1:0]      sum_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [hfp_pkg::ProbW-1:0]     out_data_reg;
    logic [hfp_pkg::ProbW-1:0]     out_data_next;
    logic [hfp_pkg::SymbolW-1:0]   sym_reg;
    logic                          first_reg;
    logic                          last_reg;
    logic                          accept;
    logic                          observe;

    assign in_ready             = (state_reg == S_IDLE);
    assign accept               = in_valid && in_ready;
    assign observe              = accept && (action == hfp_pkg::ACT_OBSERVE);
    assign out_valid            = out_valid_reg;
    assign sequence_probability = out_data_reg;

    assign wr.en     = accept && (action != hfp_pkg::ACT_OBSERVE);
    assign wr.action = hfp_pkg::action_t'(action);
    assign wr.row    = row_state;
    assign wr.col    = column_index;
    assign wr.weight = weight;

    always_comb
    begin
        cmd            = '0;
        cmd.use_init   = first_reg;
        cmd.sym        = sym_reg[hfp_pkg::SymIdxW-1:0];
        cmd.sym_ok     = int'(sym_reg) < hfp_pkg::NumSymbols;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (observe)
                begin
                    cmd.load_rot = 1'b1;
                    cnt_next     = '0;
                    state_next   = first_item ? S_EMUL : S_MAC;
                end
            end
            S_MAC:
            begin
                if (cnt_reg != hfp_pkg::CntW'(hfp_pkg::NumStates))
                begin
                    cmd.mac_mul = 1'b1;
                    cmd.shift   = 1'b1;
                end
                if (cnt_reg != '0)
                begin
                    cmd.mac_acc = 1'b1;
                end
                if (cnt_reg == hfp_pkg::CntW'(hfp_pkg::NumStates))
                begin
                    cnt_next   = '0;
                    state_next = S_EMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMUL:
            begin
                cmd.emis_mul = 1'b1;
                state_next   = S_EWR;
            end
            S_EWR:
            begin
                cmd.alpha_wr = 1'b1;
                if (last_reg)
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                cmd.shift = 1'b1;
                sum_next  = sum_reg + hfp_pkg::AccW'(rot0);
                if (cnt_reg == hfp_pkg::CntW'(hfp_pkg::NumStates - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = hfp_pkg::sat_prob(sum_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
        if (observe)
        begin
            sym_reg   <= symbol;
            first_reg <= first_item;
            last_reg  <= last_item;
        end
    end

endmodule

// ===== rtl/hmm_forward_probability_unit.sv =====
// Sequencing: an observe word runs an accumulate pass around the ring of per-state cells,
// then an emission multiply and a forward-value write (the first mark skips the accumulate
// pass), plus a final sum pass around the ring when the last mark is set.
// Throughput: one load word per cycle while the sequencer is idle; an observe word holds off
// the next word until its accumulate and sum passes around the ring and the result hand-off are done.
// Reset: async active low; clears control and forward values, tables stay undefined.
module hmm_forward_probability_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [hfp_pkg::RowW-1:0]     row_state,
    input  logic [hfp_pkg::ColW-1:0]     column_index,
    input  logic [hfp_pkg::ProbW-1:0]    weight,
    input  logic [hfp_pkg::SymbolW-1:0]  symbol,
    input  logic                         first_item,
    input  logic                         last_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hfp_pkg::ProbW-1:0]    sequence_probability
);

    hfp_pkg::tbl_wr_t           wr;
    hfp_pkg::cell_cmd_t         cmd;
    logic [hfp_pkg::ProbW-1:0]  rot [hfp_pkg::NumStates];

    hfp_ctrl u_ctrl (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .action               (action),
        .row_state            (row_state),
        .column_index         (column_index),
        .weight               (weight),
        .symbol               (symbol),
        .first_item           (first_item),
        .last_item            (last_item),
        .rot0                 (rot[0]),
        .wr                   (wr),
        .cmd                  (cmd),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .sequence_probability (sequence_probability)
    );

    for (genvar i = 0; i < hfp_pkg::NumStates; i++)
    begin : g_cell
        localparam int Nxt = (i + 1) % hfp_pkg::NumStates;

        hfp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (hfp_pkg::StateW'(i)),
            .cmd     (cmd),
            .wr      (wr),
            .rot_in  (rot[Nxt]),
            .rot_out (rot[i])
        );
    end

endmodule

// ===== tb/sv/tb_hmm_forward_probability_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HMM forward probability unit: table loads, observation sequences, sums.
module tb_hmm_forward_probability_unit;
    import hfp_pkg::*;

    localparam int HalfPeriod  = 10;
    localparam int ResetCycles = 6;
    localparam int CycleLimit  = 600000;
    localparam int DrainCycles = 4 * NumStates + 16;
    localparam int LongHold    = 400;

    logic               clk                  = 1'b0;
    logic               rst_n                = 1'b0;
    logic               in_valid             = 1'b0;
    logic               in_ready;
    logic [1:0]         action               = ACT_TRANS;
    logic [RowW-1:0]    row_state            = '0;
    logic [ColW-1:0]    column_index         = '0;
    logic [ProbW-1:0]   weight               = '0;
    logic [SymbolW-1:0] symbol               = '0;
    logic               first_item           = 1'b0;
    logic               last_item            = 1'b0;
    logic               out_valid;
    logic               out_ready            = 1'b0;
    logic [ProbW-1:0]   sequence_probability;

    logic [ProbW-1:0] trans_w [NumStates*NumStates];
    logic [ProbW-1:0] emis_w  [NumStates*NumSymbols];
    logic [ProbW-1:0] init_w  [NumStates];
    logic [ProbW-1:0] alpha   [NumStates];
    logic [ProbW-1:0] pending_probs [$];

    int errors      = 0;
    int cycle_count = 0;
    bit idle_en     = 1'b1;
    bit hold_req    = 1'b0;

    always #HalfPeriod clk = ~clk;

    hmm_forward_probability_unit i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .action               (action),
        .row_state            (row_state),
        .column_index         (column_index),
        .weight               (weight),
        .symbol               (symbol),
        .first_item           (first_item),
        .last_item            (last_item),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .sequence_probability (sequence_probability)
    );

    initial
    begin
        for (int i = 0; i < NumStates; i++)
        begin
            alpha[i] = '0;
        end
    end

    function automatic logic [ProbW-1:0] qmul(input logic [ProbW-1:0] a,
                                              input logic [ProbW-1:0] b);
        logic [2*ProbW-1:0] p;
        p = {{ProbW{1'b0}}, a} * {{ProbW{1'b0}}, b};
        return p[2*ProbW-1:ProbW];
    endfunction

    function automatic logic [ProbW-1:0] clamp_prob(input logic [2*ProbW-1:0] v);
        return (v > {{ProbW{1'b0}}, ProbMax}) ? ProbMax : v[ProbW-1:0];
    endfunction

    function automatic logic [ProbW-1:0] random_weight();
        logic [ProbW-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = ProbMax;
            2:       w = $urandom >> $urandom_range(8, 31);
            3:       w = ProbMax - $urandom_range(0, 255);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic forward_step(input action_t act, input logic [RowW-1:0] row,
                                input logic [ColW-1:0] col, input logic [ProbW-1:0] w,
                                input logic [SymbolW-1:0] sym, input logic first,
                                input logic last);
        logic [ProbW-1:0]   nxt [NumStates];
        logic [2*ProbW-1:0] acc;
        logic [ProbW-1:0]   e;
        case (act)
            ACT_TRANS:
            begin
                if (int'(col) < NumStates)
                    trans_w[row * NumStates + col] = w;
            end
            ACT_EMIS:
            begin
                if (int'(col) < NumSymbols)
                    emis_w[row * NumSymbols + col] = w;
            end
            ACT_INIT:
            begin
                init_w[row] = w;
            end
            default:
            begin
                for (int i = 0; i < NumStates; i++)
                begin
                    e = (int'(sym) < NumSymbols) ? emis_w[i * NumSymbols + sym] : '0;
                    if (first)
                    begin
                        nxt[i] = qmul(init_w[i], e);
                    end
                    else
                    begin
                        acc = '0;
                        for (int s = 0; s < NumStates; s++)
                        begin
                            acc += {{ProbW{1'b0}}, qmul(alpha[s], trans_w[s * NumStates + i])};
                        end
                        nxt[i] = qmul(clamp_prob(acc), e);
                    end
                end
                for (int i = 0; i < NumStates; i++)
                begin
                    alpha[i] = nxt[i];
                end
                if (last)
                begin
                    acc = '0;
                    for (int i = 0; i < NumStates; i++)
                    begin
                        acc += {{ProbW{1'b0}}, alpha[i]};
                    end
                    pending_probs.push_back(clamp_prob(acc));
                end
            end
        endcase
    endtask

    task automatic send_word(input action_t act, input logic [RowW-1:0] row,
                             input logic [ColW-1:0] col, input logic [ProbW-1:0] w,
                             input logic [SymbolW-1:0] sym, input logic first,
                             input logic last);
        if (idle_en && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(negedge clk);
        action       = act;
        row_state    = row;
        column_index = col;
        weight       = w;
        symbol       = sym;
        first_item   = first;
        last_item    = last;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        forward_step(act, row, col, w, sym, first, last);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic observe(input logic [SymbolW-1:0] sym, input logic first,
                           input logic last);
        send_word(ACT_OBSERVE, RowW'($urandom_range(0, 7)), ColW'($urandom_range(0, 15)),
                  $urandom, sym, first, last);
    endtask

    task automatic send_sequence(input int len, input bit closed);
        for (int k = 0; k < len; k++)
        begin
            observe(SymbolW'($urandom_range(0, 15)), k == 0, closed && (k == len - 1));
        end
    endtask

    task automatic random_load();
        send_word(action_t'($urandom_range(0, 2)), RowW'($urandom_range(0, 7)),
                  ColW'($urandom_range(0, 15)), random_weight(),
                  SymbolW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drain();
        while (pending_probs.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_table_load();
        for (int r = 0; r < NumStates; r++)
        begin
            for (int c = 0; c < NumStates; c++)
            begin
                send_word(ACT_TRANS, RowW'(r), ColW'(c), random_weight(),
                          SymbolW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
        for (int r = 0; r < NumStates; r++)
        begin
            for (int c = 0; c < NumSymbols; c++)
            begin
                send_word(ACT_EMIS, RowW'(r), ColW'(c), (c == 3) ? ProbMax : random_weight(),
                          SymbolW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
        for (int r = 0; r < NumStates; r++)
        begin
            send_word(ACT_INIT, RowW'(r), ColW'($urandom_range(0, 15)), ProbMax,
                      SymbolW'($urandom_range(0, 15)), 1'b0, 1'b0);
        end
    endtask

    task automatic test_observe_from_reset();
        observe(4'd5, 1'b0, 1'b1);
    endtask

    task automatic test_directed_cases();
        // drop: transition column outside the table, last mark on a load
        send_word(ACT_TRANS, 3'd2, 4'd15, ProbMax, 4'd0, 1'b0, 1'b1);
        send_word(ACT_TRANS, 3'd1, 4'd8, ProbMax, 4'd0, 1'b1, 1'b1);
        send_word(ACT_INIT, 3'd4, 4'd15, ProbMax, 4'd0, 1'b0, 1'b0);
        observe(4'd3, 1'b1, 1'b1);
        observe(4'd3, 1'b1, 1'b0);
        observe(4'd3, 1'b0, 1'b0);
        observe(4'd3, 1'b0, 1'b1);
        send_word(ACT_EMIS, 3'd0, 4'd0, '0, 4'd0, 1'b0, 1'b0);
        send_word(ACT_EMIS, 3'd7, 4'd15, ProbMax, 4'd15, 1'b1, 1'b0);
        send_word(ACT_TRANS, 3'd7, 4'd7, '0, 4'd0, 1'b0, 1'b0);
        send_word(ACT_INIT, 3'd0, 4'd0, '0, 4'd0, 1'b0, 1'b0);
        observe(4'd0, 1'b1, 1'b1);
        observe(4'd15, 1'b1, 1'b1);
        observe(4'd15, 1'b1, 1'b0);
        observe(4'd0, 1'b0, 1'b1);
        observe(4'd9, 1'b0, 1'b1);
    endtask

    task automatic test_random_sequences(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8);
                    send_sequence(len, 1'b1);
                end
                6, 7:
                begin
                    len = $urandom_range(1, 4);
                    repeat (len) random_load();
                end
                8:
                begin
                    len = 1;
                    send_word(action_t'($urandom_range(0, 3)), RowW'($urandom_range(0, 7)),
                              ColW'($urandom_range(0, 15)), random_weight(),
                              SymbolW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
                default:
                begin
                    len = $urandom_range(1, 4);
                    send_sequence(len, 1'b0);
                end
            endcase
            sent += len;
            if ($urandom_range(0, 39) == 0)
                wait_drain();
        end
    endtask

    task automatic test_long_hold();
        hold_req = 1'b1;
        repeat (12) send_sequence($urandom_range(1, 2), 1'b1);
        wait_drain();
    endtask

    task automatic test_sender_pause();
        send_sequence(3, 1'b1);
        wait_drain();
        send_sequence(2, 1'b1);
    endtask

    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            out_ready = 1'b0;
            repeat (LongHold) @(negedge clk);
            hold_req = 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            out_ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        out_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_probs.size() == 0)
            begin
                $error("sequence_probability: no word expected, actual %h",
                       sequence_probability);
                errors++;
            end
            else
            begin
                if (sequence_probability !== pending_probs[0])
                begin
                    $error("sequence_probability mismatch: expected %h, actual %h",
                           pending_probs[0], sequence_probability);
                    errors++;
                end
                void'(pending_probs.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("tb_hmm_forward_probability_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (ResetCycles) @(negedge clk);
        rst_n = 1'b1;
        test_table_load();
        test_observe_from_reset();
        test_directed_cases();
        test_random_sequences(850);
        test_long_hold();
        test_sender_pause();
        idle_en = 1'b0;
        test_random_sequences(150);
        wait_drain();
        repeat (DrainCycles) @(negedge clk);
        if (errors == 0 && pending_probs.size() == 0)
            $display("tb_hmm_forward_probability_unit: PASS");
        else
            $display("tb_hmm_forward_probability_unit: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hfp_pkg.sv
rtl/hfp_cell.sv
rtl/hfp_ctrl.sv
rtl/hmm_forward_probability_unit.sv
tb/sv/tb_hmm_forward_probability_unit.sv
